[src/malt_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the MAC address lease table.
// No dependencies; used by every module of the block.
`default_nettype none
package malt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MAC_W  = 48;
    localparam int ADDR_W = 32;
    localparam int OFF_W  = 7;

    localparam logic [OFF_W-1:0]  OFFSET_WRAP    = 7'd100;
    localparam logic [OFF_W-1:0]  OFFSET_RESTART = 7'd1;
    localparam logic [ADDR_W-1:0] ADDR_BIAS      = 32'd8;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [ADDR_W-1:0] addr;
    } t_lease;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

[src/mac_address_lease_table_top.sv]
`timescale 1ns / 1ps
// Top level of the MAC address lease table.
// Depends on malt_pkg, malt_front, malt_queue and malt_back.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one client MAC per item.
//   Output channel: o_out_valid / i_out_stall carry one result per request:
//   the leased address, a known flag and a table-full flag.
//   Config: i_cfg_we writes i_cfg_wdata into the gateway address register;
//   write only while the block is idle.
// Timing:
//   A request is scanned against the stored leases one entry per cycle
//   through the single read port of the lease memory, up to all 64 of a
//   full table; the engine starts the next item only once the last result
//   is loaded into the output register. A two-entry queue plus an input
//   register take up to three more items meanwhile.
// Reset: clears the lease count, the offset, the gateway register and all
//   handshake state; memory contents are never read before being written.
// Stall: a stalled result holds in the output register; the engine waits
//   with the next result, then the queue fills and o_in_stall rises.
`default_nettype none
module mac_address_lease_table_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [malt_pkg::ADDR_W-1:0]  i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [malt_pkg::MAC_W-1:0]   i_client_mac,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [malt_pkg::ADDR_W-1:0]  o_assigned_ip,
    output logic                              o_was_known,
    output logic                              o_table_full
);

    logic [malt_pkg::ADDR_W-1:0]  r_gateway_ip;
    malt_pkg::t_q_status          w_q_status;
    logic                         w_push;
    logic [malt_pkg::MAC_W-1:0]   w_push_mac;
    logic                         w_pop;
    logic [malt_pkg::MAC_W-1:0]   w_pop_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gateway_ip <= '0;
        end else if (i_cfg_we) begin
            r_gateway_ip <= i_cfg_wdata;
        end
    end

    malt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_client_mac (i_client_mac),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_push_mac   (w_push_mac)
    );

    malt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_mac (w_push_mac),
        .i_pop      (w_pop),
        .o_pop_mac  (w_pop_mac),
        .o_status   (w_q_status)
    );

    malt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_gateway_ip  (r_gateway_ip),
        .i_q_status    (w_q_status),
        .i_q_mac       (w_pop_mac),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_assigned_ip (o_assigned_ip),
        .o_was_known   (o_was_known),
        .o_table_full  (o_table_full)
    );

endmodule
`default_nettype wire

[src/malt_queue.sv]
`timescale 1ns / 1ps
// Two-entry request queue between the front and back parts.
// Depends on malt_pkg.
`default_nettype none
module malt_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic [malt_pkg::MAC_W-1:0]  i_push_mac,
    input  wire logic                        i_pop,
    output logic      [malt_pkg::MAC_W-1:0]  o_pop_mac,
    output malt_pkg::t_q_status              o_status
);

    logic [malt_pkg::MAC_W-1:0]   r_slot [malt_pkg::Q_DEPTH];
    logic [malt_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [malt_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [malt_pkg::Q_CNT_W-1:0] r_count;
    logic                         w_push;
    logic                         w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == malt_pkg::Q_CNT_W'(malt_pkg::Q_DEPTH));
    assign w_push    = i_push && !o_status.full;
    assign w_pop     = i_pop && !o_status.empty;
    assign o_pop_mac = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/malt_front.sv]
`timescale 1ns / 1ps
// Request intake: registers each accepted item and hands it to the queue.
// Depends on malt_pkg.
`default_nettype none
module malt_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [malt_pkg::MAC_W-1:0]  i_client_mac,
    input  malt_pkg::t_q_status              i_q_status,
    output logic                             o_push,
    output logic      [malt_pkg::MAC_W-1:0]  o_push_mac
);

    logic                         r_valid;
    logic [malt_pkg::MAC_W-1:0]   r_mac;
    logic                         w_accept;

    assign o_in_stall = r_valid && i_q_status.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_status.full;
    assign o_push_mac = r_mac;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mac <= i_client_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[src/malt_back.sv]
`timescale 1ns / 1ps
// Lease engine: scans the lease memory, makes new leases, drives the result register.
// Depends on malt_pkg.
`default_nettype none
module malt_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [malt_pkg::ADDR_W-1:0]  i_gateway_ip,
    input  malt_pkg::t_q_status               i_q_status,
    input  wire logic [malt_pkg::MAC_W-1:0]   i_q_mac,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [malt_pkg::ADDR_W-1:0]  o_assigned_ip,
    output logic                              o_was_known,
    output logic                              o_table_full
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MISS = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    malt_pkg::t_lease r_mem [malt_pkg::TABLE_DEPTH];
    malt_pkg::t_lease r_rd_data;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [malt_pkg::MAC_W-1:0]    r_mac;
    logic [malt_pkg::CNT_W-1:0]    r_rd_idx;
    logic                          r_pend;
    logic [malt_pkg::CNT_W-1:0]    r_count;
    logic [malt_pkg::OFF_W-1:0]    r_offset;
    logic [malt_pkg::OFF_W-1:0]    n_offset;
    logic [malt_pkg::ADDR_W-1:0]   r_res_addr;
    logic                          r_res_known;
    logic                          r_res_full;
    logic                          r_out_valid;
    logic [malt_pkg::ADDR_W-1:0]   r_out_addr;
    logic                          r_out_known;
    logic                          r_out_full;

    logic                          w_issue;
    logic                          w_hit;
    logic                          w_full;
    logic                          w_store;
    logic                          w_load;
    logic [malt_pkg::ADDR_W-1:0]   w_new_addr;

    assign w_issue    = (r_state == S_SCAN) && (r_rd_idx != r_count);
    assign w_hit      = (r_state == S_SCAN) && r_pend && (r_rd_data.mac == r_mac);
    assign w_full     = (r_count == malt_pkg::CNT_W'(malt_pkg::TABLE_DEPTH));
    assign w_store    = (r_state == S_MISS) && !w_full;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_pop      = (r_state == S_IDLE) && !i_q_status.empty;
    assign w_new_addr = i_gateway_ip + malt_pkg::ADDR_W'(r_offset) + malt_pkg::ADDR_BIAS;

    assign o_out_valid   = r_out_valid;
    assign o_assigned_ip = r_out_addr;
    assign o_was_known   = r_out_known;
    assign o_table_full  = r_out_full;

    always_comb begin
        if (r_offset + 1'b1 >= malt_pkg::OFFSET_WRAP) begin
            n_offset = malt_pkg::OFFSET_RESTART;
        end else begin
            n_offset = r_offset + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_DONE;
                end else if (!w_issue && !r_pend) begin
                    n_state = S_MISS;
                end
            end
            S_MISS: n_state = S_DONE;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[malt_pkg::IDX_W-1:0]] <= '{mac: r_mac, addr: w_new_addr};
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_idx[malt_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mac <= i_q_mac;
        end
        if (w_hit) begin
            r_res_addr  <= r_rd_data.addr;
            r_res_known <= 1'b1;
            r_res_full  <= 1'b0;
        end else if (r_state == S_MISS) begin
            r_res_addr  <= w_new_addr;
            r_res_known <= 1'b0;
            r_res_full  <= w_full;
        end
        if (w_load) begin
            r_out_addr  <= r_res_addr;
            r_out_known <= r_res_known;
            r_out_full  <= r_res_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_rd_idx <= '0;
                r_pend   <= 1'b0;
            end else if (w_issue && !w_hit) begin
                r_rd_idx <= r_rd_idx + 1'b1;
                r_pend   <= 1'b1;
            end else begin
                r_pend   <= 1'b0;
            end
            if (r_state == S_MISS) begin
                r_offset <= n_offset;
            end
            if (w_store) begin
                r_count <= r_count + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[src/malt_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the MAC address lease table, bound to the top level.
// Depends on malt_pkg and mac_address_lease_table_top.
`default_nettype none
module malt_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         o_in_stall,
    input  wire logic [malt_pkg::MAC_W-1:0]   i_client_mac,
    input  wire logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic [malt_pkg::ADDR_W-1:0]  o_assigned_ip,
    input  wire logic                         o_was_known,
    input  wire logic                         o_table_full
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_assigned_ip)
            && $stable(o_was_known) && $stable(o_table_full))
        else $error("stalled result item changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_client_mac))
        else $error("stalled input item changed");

    a_known_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_known |-> !o_table_full)
        else $error("known lease reported table full");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshake not idle after reset");

endmodule

bind mac_address_lease_table_top malt_checker u_malt_checker (.*);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for mac_address_lease_table_top: lease lookups and
// new leases, checked against a lease table predictor kept in the testbench.
// Depends on malt_pkg and the RTL of the block.
module testbench;

    localparam int          CLK_HALF     = 5;
    localparam int          IDLE_PCT     = 34;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          HOLD_AT      = 200;
    localparam int          PHASE_ITEMS  = 120;
    localparam logic [6:0]  OFF_WRAP     = 7'd100;
    localparam logic [6:0]  OFF_RESTART  = 7'd1;
    localparam logic [31:0] LEASE_BIAS   = 32'd8;
    localparam logic [malt_pkg::MAC_W-1:0] MAC_ONES = '1;

    typedef struct packed {
        logic [malt_pkg::ADDR_W-1:0] addr;
        logic                        known;
        logic                        full;
    } t_lease_reply;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_cfg_we     = 1'b0;
    logic [malt_pkg::ADDR_W-1:0] i_cfg_wdata  = '0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_stall;
    logic [malt_pkg::MAC_W-1:0]  i_client_mac = '0;
    logic                        o_out_valid;
    logic                        i_out_stall  = 1'b0;
    logic [malt_pkg::ADDR_W-1:0] o_assigned_ip;
    logic                        o_was_known;
    logic                        o_table_full;

    // predictor state
    logic [malt_pkg::MAC_W-1:0]  lease_macs  [malt_pkg::TABLE_DEPTH];
    logic [malt_pkg::ADDR_W-1:0] lease_addrs [malt_pkg::TABLE_DEPTH];
    bit                          lease_used  [malt_pkg::TABLE_DEPTH];
    int                          leases_stored = 0;
    logic [6:0]                  lease_offset  = '0;
    logic [malt_pkg::ADDR_W-1:0] gateway_addr  = '0;

    logic [malt_pkg::MAC_W-1:0]  pending_macs[$];
    logic [malt_pkg::MAC_W-1:0]  seen_macs[$];
    t_lease_reply                expected_replies[$];

    int errors       = 0;
    int replies_seen = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    mac_address_lease_table_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_client_mac  (i_client_mac),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_assigned_ip (o_assigned_ip),
        .o_was_known   (o_was_known),
        .o_table_full  (o_table_full)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_lease_reply lease_lookup(logic [malt_pkg::MAC_W-1:0] mac);
        t_lease_reply reply;
        logic [6:0]   off_now;
        reply = '0;
        for (int i = 0; i < malt_pkg::TABLE_DEPTH; i++) begin
            if (lease_used[i] && lease_macs[i] == mac) begin
                reply.addr  = lease_addrs[i];
                reply.known = 1'b1;
                return reply;
            end
        end
        off_now      = lease_offset;
        lease_offset = (lease_offset + 7'd1 >= OFF_WRAP) ? OFF_RESTART : lease_offset + 7'd1;
        reply.addr   = gateway_addr + {25'd0, off_now} + LEASE_BIAS;
        if (leases_stored < malt_pkg::TABLE_DEPTH) begin
            lease_macs[leases_stored]  = mac;
            lease_addrs[leases_stored] = reply.addr;
            lease_used[leases_stored]  = 1'b1;
            leases_stored++;
        end else begin
            reply.full = 1'b1;
        end
        return reply;
    endfunction

    // driver: present pending items, hold each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_replies.push_back(lease_lookup(i_client_mac));
                quiet_cycles = 0;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_macs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid   <= 1'b1;
                    i_client_mac <= pending_macs.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_lease_reply want;
        static int    hold_left = 0;
        static bit    hold_done = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item: ip=%h known=%b full=%b", $time,
                             o_assigned_ip, o_was_known, o_table_full);
                end else begin
                    want = expected_replies.pop_front();
                    if (o_assigned_ip !== want.addr) begin
                        errors++;
                        $display("%0t: assigned_ip expected %h actual %h", $time,
                                 want.addr, o_assigned_ip);
                    end
                    if (o_was_known !== want.known) begin
                        errors++;
                        $display("%0t: was_known expected %b actual %b", $time,
                                 want.known, o_was_known);
                    end
                    if (o_table_full !== want.full) begin
                        errors++;
                        $display("%0t: table_full expected %b actual %b", $time,
                                 want.full, o_table_full);
                    end
                end
            end
            // hold off once for a long stretch so the block backs up
            if (!hold_done && replies_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_macs.size() > 0 || i_in_valid || expected_replies.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gateway(logic [malt_pkg::ADDR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= value;
        gateway_addr  = value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_mac(logic [malt_pkg::MAC_W-1:0] mac);
        pending_macs.push_back(mac);
        seen_macs.push_back(mac);
    endtask

    task automatic run_random_phase(int count);
        logic [malt_pkg::MAC_W-1:0] mac;
        int                         pick;
        int                         top;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            top  = (seen_macs.size() > 80 && pick < 25) ? 79 : seen_macs.size() - 1;
            if (pick < 45) begin
                mac = seen_macs[$urandom_range(top)];
            end else if (pick < 55) begin
                mac = seen_macs[$urandom_range(top)]
                      ^ (48'd1 << $urandom_range(malt_pkg::MAC_W - 1));
            end else if (pick < 92) begin
                mac = malt_pkg::MAC_W'({$urandom, $urandom});
            end else begin
                case ($urandom_range(3))
                    0: mac = '0;
                    1: mac = MAC_ONES;
                    2: mac = 48'd1 << $urandom_range(malt_pkg::MAC_W - 1);
                    default: mac = ~seen_macs[$urandom_range(top)];
                endcase
            end
            push_mac(mac);
        end
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < malt_pkg::TABLE_DEPTH; i++) lease_used[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_gateway(32'hC0A8_0001);
        push_mac('0);
        push_mac(MAC_ONES);
        push_mac('0);
        push_mac(48'hAAAA_AAAA_AAAA);
        push_mac(48'h5555_5555_5555);
        push_mac(MAC_ONES);
        push_mac(48'h8000_0000_0000);
        push_mac(48'h0000_0000_0001);
        push_mac(48'h0000_0000_0001);
        wait_idle();

        // wrap of the address sum
        write_gateway(32'hFFFF_FFFF);
        push_mac('0);
        push_mac(48'h0012_3456_789A);
        push_mac(48'hFFFF_FFFF_FFFE);
        push_mac(48'h0012_3456_789A);
        wait_idle();

        write_gateway(32'h0000_0000);
        push_mac(48'h0123_4567_89AB);
        push_mac(48'hAAAA_AAAA_AAAA);
        push_mac(48'h0000_0000_0002);
        wait_idle();

        write_gateway($urandom);
        run_random_phase(PHASE_ITEMS);
        write_gateway(32'hFFFF_FFF8);
        run_random_phase(PHASE_ITEMS);
        write_gateway(32'h0000_0000);
        run_random_phase(PHASE_ITEMS);
        @(posedge i_clk);
        calm <= 1'b1;
        write_gateway(32'hFFFF_FFFF);
        run_random_phase(PHASE_ITEMS);
        @(posedge i_clk);
        calm <= 1'b0;
        write_gateway($urandom);
        run_random_phase(PHASE_ITEMS);

        if (errors == 0 && expected_replies.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/malt_pkg.sv
src/malt_queue.sv
src/malt_front.sv
src/malt_back.sv
src/mac_address_lease_table_top.sv
src/malt_checker.sv
tb/sv/testbench.sv
